>>> rtl/dma_prd_table_builder_defines.svh
// ----------------------------------------------------------------------------
// DMA PRD table builder: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef DMA_PRD_TABLE_BUILDER_DEFINES_SVH
`define DMA_PRD_TABLE_BUILDER_DEFINES_SVH

// cond holds at every clock edge out of reset
`define DPB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// cons holds in the same cycle as ante
`define DPB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/dpb_pkg.sv
// ----------------------------------------------------------------------------
// DMA PRD table builder: package
// Field types, result and error codes, and shared constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpb_pkg;

    localparam int unsigned PAGE_BYTES_DEF  = 4096;
    localparam int unsigned MAX_ENTRIES_DEF = 512;
    localparam int unsigned MAX_TRANSFER    = 65536;
    localparam int unsigned OUTQ_DEPTH      = 4;

    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned CNT_W   = 17;
    localparam int unsigned LEN_W   = 13;
    localparam int unsigned IDX_W   = 9;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned ERR_W   = 3;
    localparam int unsigned QCNT_W  = $clog2(OUTQ_DEPTH + 1);

    localparam logic [CNT_W-1:0] BOUND_64K = 17'h10000;
    localparam logic [32:0]      LIMIT_4G  = 33'h1_0000_0000;

    localparam logic REQ_BEGIN  = 1'b0;
    localparam logic REQ_ANSWER = 1'b1;

    localparam logic [KIND_W-1:0] KIND_XLATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DESC  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERR   = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_SIZE  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_ODD_ADDR  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_UNMAPPED  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TBL_FULL  = 3'd4;
    localparam logic [ERR_W-1:0] ERR_BEYOND_4G = 3'd5;

    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] virt_addr;
        logic [CNT_W-1:0]  xfer_bytes;
        logic [ADDR_W-1:0] phys_addr;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  byte_len;
        logic              end_of_table;
        logic [IDX_W-1:0]  entry_index;
        logic [ERR_W-1:0]  error_code;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  first;
        t_out_item  second;
    } t_push;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              room;
    } t_q_status;

    function automatic t_out_item mk_item(
        input logic [KIND_W-1:0] kind,
        input logic [ADDR_W-1:0] addr,
        input logic [LEN_W-1:0]  len,
        input logic              eot,
        input logic [IDX_W-1:0]  idx,
        input logic [ERR_W-1:0]  err,
        input logic              last
    );
        t_out_item item;
        item.result_kind  = kind;
        item.addr         = addr;
        item.byte_len     = len;
        item.end_of_table = eot;
        item.entry_index  = idx;
        item.error_code   = err;
        item.last         = last;
        return item;
    endfunction

    function automatic t_out_item mk_error(input logic [ERR_W-1:0] err);
        return mk_item(KIND_ERR, '0, '0, 1'b0, '0, err, 1'b1);
    endfunction

endpackage

>>> rtl/dpb_core.sv
// ----------------------------------------------------------------------------
// DMA PRD table builder: core
// Input register, transfer state and combinational descriptor step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpb_core #(
    parameter int unsigned PAGE_BYTES  = dpb_pkg::PAGE_BYTES_DEF,
    parameter int unsigned MAX_ENTRIES = dpb_pkg::MAX_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dpb_pkg::t_in_item  i_in_data,
    input  dpb_pkg::t_q_status i_q_status,
    output dpb_pkg::t_push     o_push
);

    localparam int unsigned PW = $clog2(PAGE_BYTES);
    localparam int unsigned EW = $clog2(MAX_ENTRIES);
    localparam logic [dpb_pkg::CNT_W-1:0] PAGE_SZ = dpb_pkg::CNT_W'(PAGE_BYTES);
    localparam logic [dpb_pkg::CNT_W-1:0] MAX_XFER = dpb_pkg::CNT_W'(dpb_pkg::MAX_TRANSFER);
    localparam logic [EW-1:0] LAST_ENTRY = EW'(MAX_ENTRIES - 1);

    logic                            r_in_vld;
    dpb_pkg::t_in_item               r_in;
    logic                            r_active, n_active;
    logic [dpb_pkg::ADDR_W-1:0]      r_cur, n_cur;
    logic [dpb_pkg::CNT_W-1:0]       r_rem, n_rem;
    logic [EW-1:0]                   r_entries, n_entries;

    logic                            go;
    logic                            load;
    logic [dpb_pkg::CNT_W-1:0]       chunk_pg;
    logic [dpb_pkg::CNT_W-1:0]       to64k;
    logic [dpb_pkg::CNT_W-1:0]       clip1;
    logic [dpb_pkg::CNT_W-1:0]       chunk;
    logic [32:0]                     end33;
    logic                            beyond;
    logic                            bad_size;
    logic [dpb_pkg::ADDR_W-1:0]      next_cur;
    logic [dpb_pkg::IDX_W-1:0]       idx;

    assign go         = r_in_vld && i_q_status.room;
    assign o_in_stall = r_in_vld && !i_q_status.room;
    assign load       = i_in_valid && !o_in_stall;

    // clip to page end, 64 KB physical boundary and bytes left
    assign chunk_pg = PAGE_SZ - dpb_pkg::CNT_W'(r_cur[PW-1:0]);
    assign to64k    = dpb_pkg::BOUND_64K - {1'b0, r_in.phys_addr[15:0]};
    assign clip1    = (chunk_pg > to64k) ? to64k : chunk_pg;
    assign chunk    = (clip1 > r_rem) ? r_rem : clip1;
    assign end33    = {1'b0, r_in.phys_addr[31:0]} + 33'(chunk);
    assign beyond   = (|r_in.phys_addr[63:32]) || (end33 > dpb_pkg::LIMIT_4G);
    assign bad_size = (r_in.xfer_bytes == '0) || (r_in.xfer_bytes > MAX_XFER);
    assign next_cur = r_cur + dpb_pkg::ADDR_W'(chunk);
    assign idx      = dpb_pkg::IDX_W'(r_entries);

    always_comb begin
        n_active  = r_active;
        n_cur     = r_cur;
        n_rem     = r_rem;
        n_entries = r_entries;
        o_push    = '0;
        if (go) begin
            if (r_in.req_type == dpb_pkg::REQ_BEGIN) begin
                n_active   = 1'b0;
                o_push.cnt = dpb_pkg::PUSH_ONE;
                if (bad_size) begin
                    o_push.first = dpb_pkg::mk_error(dpb_pkg::ERR_BAD_SIZE);
                end else if (r_in.virt_addr[0]) begin
                    o_push.first = dpb_pkg::mk_error(dpb_pkg::ERR_ODD_ADDR);
                end else begin
                    n_active     = 1'b1;
                    n_cur        = r_in.virt_addr;
                    n_rem        = r_in.xfer_bytes;
                    n_entries    = '0;
                    o_push.first = dpb_pkg::mk_item(dpb_pkg::KIND_XLATE, r_in.virt_addr,
                                                    '0, 1'b0, '0, dpb_pkg::ERR_NONE, 1'b1);
                end
            end else if (r_active) begin
                o_push.cnt = dpb_pkg::PUSH_ONE;
                if (r_in.phys_addr == '0) begin
                    n_active     = 1'b0;
                    o_push.first = dpb_pkg::mk_error(dpb_pkg::ERR_UNMAPPED);
                end else if (beyond) begin
                    n_active     = 1'b0;
                    o_push.first = dpb_pkg::mk_error(dpb_pkg::ERR_BEYOND_4G);
                end else begin
                    n_rem      = r_rem - chunk;
                    n_cur      = next_cur;
                    n_entries  = r_entries + 1'b1;
                    o_push.cnt = dpb_pkg::PUSH_TWO;
                    if (r_rem == chunk) begin
                        n_active      = 1'b0;
                        o_push.first  = dpb_pkg::mk_item(dpb_pkg::KIND_DESC, r_in.phys_addr,
                                                         dpb_pkg::LEN_W'(chunk), 1'b1, idx,
                                                         dpb_pkg::ERR_NONE, 1'b0);
                        o_push.second = dpb_pkg::mk_item(dpb_pkg::KIND_DONE, '0, '0, 1'b0,
                                                         '0, dpb_pkg::ERR_NONE, 1'b1);
                    end else begin
                        o_push.first = dpb_pkg::mk_item(dpb_pkg::KIND_DESC, r_in.phys_addr,
                                                        dpb_pkg::LEN_W'(chunk), 1'b0, idx,
                                                        dpb_pkg::ERR_NONE, 1'b0);
                        if (r_entries == LAST_ENTRY) begin
                            n_active      = 1'b0;
                            o_push.second = dpb_pkg::mk_error(dpb_pkg::ERR_TBL_FULL);
                        end else begin
                            o_push.second = dpb_pkg::mk_item(dpb_pkg::KIND_XLATE, next_cur,
                                                             '0, 1'b0, '0,
                                                             dpb_pkg::ERR_NONE, 1'b1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_active  <= 1'b0;
            r_cur     <= '0;
            r_rem     <= '0;
            r_entries <= '0;
        end else begin
            if (load) begin
                r_in_vld <= 1'b1;
            end else if (go) begin
                r_in_vld <= 1'b0;
            end
            r_active  <= n_active;
            r_cur     <= n_cur;
            r_rem     <= n_rem;
            r_entries <= n_entries;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in <= i_in_data;
        end
    end

endmodule

>>> rtl/dpb_outq.sv
// ----------------------------------------------------------------------------
// DMA PRD table builder: result queue
// Takes up to two results a cycle and hands them out one per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpb_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dpb_pkg::t_push      i_push,
    output dpb_pkg::t_q_status  o_status,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dpb_pkg::t_out_item  o_out_data
);

    localparam int unsigned QPW = $clog2(dpb_pkg::OUTQ_DEPTH);
    localparam logic [dpb_pkg::QCNT_W-1:0] ROOM_MAX =
        dpb_pkg::QCNT_W'(dpb_pkg::OUTQ_DEPTH - 2);

    dpb_pkg::t_out_item              r_mem [dpb_pkg::OUTQ_DEPTH];
    logic [QPW-1:0]                  r_wr, n_wr;
    logic [QPW-1:0]                  r_rd, n_rd;
    logic [dpb_pkg::QCNT_W-1:0]      r_count, n_count;
    logic [QPW-1:0]                  wr_nxt;
    logic                            pop;

    assign pop         = (r_count != '0) && !i_out_stall;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rd];
    assign wr_nxt      = r_wr + 1'b1;

    assign o_status.count = r_count;
    assign o_status.room  = (r_count <= ROOM_MAX);

    always_comb begin
        n_rd    = pop ? QPW'(r_rd + 1'b1) : r_rd;
        n_count = r_count + dpb_pkg::QCNT_W'(i_push.cnt) - dpb_pkg::QCNT_W'(pop);
        unique case (i_push.cnt)
            dpb_pkg::PUSH_ONE: n_wr = wr_nxt;
            dpb_pkg::PUSH_TWO: n_wr = QPW'(r_wr + 2'd2);
            default:           n_wr = r_wr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != dpb_pkg::PUSH_NONE) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.cnt == dpb_pkg::PUSH_TWO) begin
            r_mem[wr_nxt] <= i_push.second;
        end
    end

endmodule

>>> rtl/dma_prd_table_builder.sv
// ----------------------------------------------------------------------------
// DMA PRD table builder
// Builds a scatter-gather descriptor list for a bus-master DMA transfer.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data): a begin item opens a
// transfer, an answer item returns the physical address for the last
// translate request. Output channel (o_out_valid / i_out_stall / o_out_data)
// carries translate requests, descriptors, done and error results; the last
// result of each input item has last set.
// An input item is registered, and its results pass through the result
// queue. Throughput: one item per cycle while items give one result each
// and the output does not stall; an item with two results needs two output
// transfers; the output port (one result per cycle) sets the sustained rate.
// The input register holds one item; the result queue holds four results
// and takes a new item only while two places are free.
// Reset (synchronous, active low) empties the queue and the input register
// and returns the block to idle. A stall on the output holds the offered
// result; the queue fills and then stalls the input channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dma_prd_table_builder_defines.svh"

module dma_prd_table_builder #(
    parameter int unsigned PAGE_BYTES  = dpb_pkg::PAGE_BYTES_DEF,
    parameter int unsigned MAX_ENTRIES = dpb_pkg::MAX_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dpb_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dpb_pkg::t_out_item  o_out_data
);

    dpb_pkg::t_push     push;
    dpb_pkg::t_q_status q_stat;

    dpb_core #(
        .PAGE_BYTES  (PAGE_BYTES),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_status (q_stat),
        .o_push     (push)
    );

    dpb_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_status    (q_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    `DPB_ASSERT_ALWAYS(a_queue_bound, q_stat.count <= dpb_pkg::QCNT_W'(dpb_pkg::OUTQ_DEPTH), "result queue overflow")
    `DPB_ASSERT_IMPLIES(a_push_room, push.cnt != dpb_pkg::PUSH_NONE, q_stat.room, "push without room")
    `DPB_ASSERT_IMPLIES(a_pair_last, push.cnt == dpb_pkg::PUSH_TWO, !push.first.last && push.second.last, "bad last mark on result pair")
    `DPB_ASSERT_IMPLIES(a_single_last, push.cnt == dpb_pkg::PUSH_ONE, push.first.last, "single result without last")

endmodule

>>> test/tb_dma_prd_table_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA PRD table builder: self-checking testbench
// Drives begin and translation answer items into the block, predicts every
// translate request, descriptor, done and error result, and checks each
// output transfer in order against the prediction. A directed opening covers
// field extremes and error paths, then random transfers, broken sequences,
// noise and long tables that fill up, under random idling on both sides.
// ----------------------------------------------------------------------------

module tb_dma_prd_table_builder;

    import dpb_pkg::*;

    localparam int unsigned ITEM_GOAL   = 1600;
    localparam int unsigned QUIET_AFTER = 1450;
    localparam int unsigned STUCK_LIMIT = 2000;

    class prd_scoreboard;
        logic [ADDR_W-1:0] cur_virt;
        logic [CNT_W-1:0]  bytes_left;
        logic [9:0]        built;
        bit                running;
        t_out_item         awaited_results[$];
        int unsigned       mismatch_total;

        function new();
            cur_virt       = '0;
            bytes_left     = '0;
            built          = '0;
            running        = 1'b0;
            mismatch_total = 0;
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        function void push_result(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                  logic [LEN_W-1:0] len, logic eot,
                                  logic [IDX_W-1:0] idx, logic [ERR_W-1:0] err,
                                  logic last);
            t_out_item r;
            r.result_kind  = kind;
            r.addr         = addr;
            r.byte_len     = len;
            r.end_of_table = eot;
            r.entry_index  = idx;
            r.error_code   = err;
            r.last         = last;
            awaited_results.push_back(r);
        endfunction

        // Predict the results of one accepted input transfer.
        function void note_request(t_in_item it);
            logic [63:0]      pa;
            logic [63:0]      page_left;
            logic [63:0]      to_bound;
            logic [63:0]      chunk;
            logic [IDX_W-1:0] idx;
            if (it.req_type == REQ_BEGIN) begin
                running = 1'b0;
                if (it.xfer_bytes == 0 || it.xfer_bytes > MAX_TRANSFER) begin
                    push_result(KIND_ERR, '0, '0, 1'b0, '0, ERR_BAD_SIZE, 1'b1);
                    return;
                end
                if (it.virt_addr[0]) begin
                    push_result(KIND_ERR, '0, '0, 1'b0, '0, ERR_ODD_ADDR, 1'b1);
                    return;
                end
                cur_virt   = it.virt_addr;
                bytes_left = it.xfer_bytes;
                built      = '0;
                running    = 1'b1;
                push_result(KIND_XLATE, it.virt_addr, '0, 1'b0, '0, ERR_NONE, 1'b1);
                return;
            end
            if (!running)
                return;
            pa = it.phys_addr;
            if (pa == 0) begin
                running = 1'b0;
                push_result(KIND_ERR, '0, '0, 1'b0, '0, ERR_UNMAPPED, 1'b1);
                return;
            end
            page_left = 64'(PAGE_BYTES_DEF) - (cur_virt & (64'(PAGE_BYTES_DEF) - 64'd1));
            to_bound  = 64'h10000 - (pa & 64'hFFFF);
            chunk     = page_left;
            if (chunk > to_bound)
                chunk = to_bound;
            if (chunk > 64'(bytes_left))
                chunk = 64'(bytes_left);
            if (pa > 64'h1_0000_0000 - chunk) begin
                running = 1'b0;
                push_result(KIND_ERR, '0, '0, 1'b0, '0, ERR_BEYOND_4G, 1'b1);
                return;
            end
            idx        = built[IDX_W-1:0];
            bytes_left = bytes_left - chunk[CNT_W-1:0];
            cur_virt   = cur_virt + chunk;
            built      = built + 10'd1;
            if (bytes_left == 0) begin
                running = 1'b0;
                push_result(KIND_DESC, pa, chunk[LEN_W-1:0], 1'b1, idx, ERR_NONE, 1'b0);
                push_result(KIND_DONE, '0, '0, 1'b0, '0, ERR_NONE, 1'b1);
                return;
            end
            push_result(KIND_DESC, pa, chunk[LEN_W-1:0], 1'b0, idx, ERR_NONE, 1'b0);
            if (built >= MAX_ENTRIES_DEF) begin
                running = 1'b0;
                push_result(KIND_ERR, '0, '0, 1'b0, '0, ERR_TBL_FULL, 1'b1);
                return;
            end
            push_result(KIND_XLATE, cur_virt, '0, 1'b0, '0, ERR_NONE, 1'b1);
        endfunction

        function bit field_differs(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            bit        bad;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d addr %0h",
                         $time, got.result_kind, got.addr);
                mismatch_total++;
                return;
            end
            want = awaited_results.pop_front();
            bad  = field_differs("result_kind", want.result_kind, got.result_kind);
            bad |= field_differs("addr", want.addr, got.addr);
            bad |= field_differs("byte_len", want.byte_len, got.byte_len);
            bad |= field_differs("end_of_table", want.end_of_table, got.end_of_table);
            bad |= field_differs("entry_index", want.entry_index, got.entry_index);
            bad |= field_differs("error_code", want.error_code, got.error_code);
            bad |= field_differs("last", want.last, got.last);
            if (bad)
                mismatch_total++;
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    prd_scoreboard sb = new();

    int unsigned items_sent  = 0;
    int unsigned gap_pct     = 0;
    bit          quiet       = 1'b0;
    int unsigned stall_left  = 0;
    int unsigned stall_pct   = 0;
    int unsigned stall_span  = 0;
    int unsigned stuck_count = 0;

    dma_prd_table_builder #(
        .PAGE_BYTES  (PAGE_BYTES_DEF),
        .MAX_ENTRIES (MAX_ENTRIES_DEF)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_in_data);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_count = 0;
        end else begin
            stuck_count++;
            if (stuck_count >= STUCK_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Stall the result channel in bursts; the burst rate changes over time.
    always @(negedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (stall_span == 0) begin
                stall_span = $urandom_range(40, 200);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    default: stall_pct = 50;
                endcase
            end else begin
                stall_span--;
            end
            if (stall_left != 0) begin
                stall_left--;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(0, 16);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [63:0] rand_word64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item make_item(logic req, logic [63:0] va,
                                           logic [CNT_W-1:0] cnt, logic [63:0] pa);
        t_in_item it;
        it.req_type   = req;
        it.virt_addr  = va;
        it.xfer_bytes = cnt;
        it.phys_addr  = pa;
        return it;
    endfunction

    task automatic idle_gap(input int unsigned n);
        i_in_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Offer one item and hold it until the transfer is taken.
    task automatic send_item(input t_in_item it, input bit counted);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (counted)
            items_sent++;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 99) < gap_pct)
            idle_gap($urandom_range(1, 17));
    endtask

    task automatic send_begin(input logic [63:0] va, input logic [CNT_W-1:0] cnt);
        send_item(make_item(REQ_BEGIN, va, cnt, rand_word64()), 1'b1);
    endtask

    task automatic send_answer(input logic [63:0] pa);
        send_item(make_item(REQ_ANSWER, rand_word64(), CNT_W'($urandom), pa), sb.running);
    endtask

    task automatic drain_wait();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // One transfer with random content; max_answers cuts it short at times.
    task automatic run_transfer(input int unsigned max_answers);
        logic [63:0]      va;
        logic [63:0]      pa;
        logic [CNT_W-1:0] cnt;
        int unsigned      answers;
        int unsigned      pick;
        va  = rand_word64() & ~64'd1;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            cnt = CNT_W'($urandom_range(1, 8192));
        else if (pick < 90)
            cnt = CNT_W'($urandom_range(1, MAX_TRANSFER));
        else
            case ($urandom_range(0, 3))
                0: cnt = CNT_W'(1);
                1: cnt = CNT_W'(2);
                2: cnt = CNT_W'(PAGE_BYTES_DEF);
                default: cnt = CNT_W'(MAX_TRANSFER);
            endcase
        send_begin(va, cnt);
        answers = 0;
        while (sb.running && answers < max_answers && items_sent < ITEM_GOAL) begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
                pa = {32'd0, $urandom};
            else if (pick < 88)
                pa = {32'd0, 16'($urandom), 16'hFFFF - 16'($urandom_range(0, 63))};
            else if (pick < 93)
                pa = '0;
            else if (pick < 97)
                pa = {32'd0, 32'hFFFF_FFFF - 32'($urandom_range(0, 4095))};
            else
                pa = rand_word64() | 64'h1_0000_0000;
            if (pa == 0 && pick < 88)
                pa = 64'h1000;
            send_answer(pa);
            answers++;
        end
    endtask

    // Descriptors of 2 to 8 bytes against the 64 KB boundary until the table is full.
    task automatic fill_table();
        send_begin(rand_word64() & ~64'd1, CNT_W'($urandom_range(4200, MAX_TRANSFER)));
        while (sb.running)
            send_answer({32'd0, 16'($urandom), 16'hFFFE - 16'(2 * $urandom_range(0, 3))});
    endtask

    initial begin
        int unsigned pick;
        int unsigned full_runs;
        full_runs = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        gap_pct = 30;
        send_item(make_item(REQ_ANSWER, rand_word64(), CNT_W'(17'h1FFFF), 64'h1000), 1'b0);
        send_begin(64'h100, CNT_W'(0));
        send_begin(64'h100, CNT_W'(MAX_TRANSFER + 1));
        send_begin(64'hFFFF_FFFF_FFFF_FFFF, CNT_W'(17'h1FFFF));
        send_begin(64'h3, CNT_W'(10));
        send_begin(64'hFFFF_FFFF_FFFF_F000, CNT_W'(MAX_TRANSFER));
        send_answer(64'h0);
        send_begin(64'h0FFE, CNT_W'(100));
        send_answer(64'h1000);
        send_answer(64'hFFFF_FFF0);
        send_answer(64'hFFFF_FF00);
        send_begin(64'h2000, CNT_W'(4096));
        send_answer(64'h1_0000_0000);
        send_begin(64'hFFFF_FFFF_FFFF_FFFE, CNT_W'(MAX_TRANSFER));
        send_answer(64'hFFFF_FFFF_FFFF_FFFE);
        send_begin(64'h10, CNT_W'(8));
        send_begin(64'h20, CNT_W'(4));
        send_answer(64'hFFFF_FFFF);
        send_answer(64'h0002_0000);
        send_begin(64'hFFFF_FFFF_FFFF_F000, CNT_W'(MAX_TRANSFER));
        send_answer(64'h8000_0000);
        send_answer(64'h7FFF_F000);
        drain_wait();

        while (items_sent < ITEM_GOAL) begin
            if (items_sent >= QUIET_AFTER && !quiet) begin
                quiet <= 1'b1;
                gap_pct = 0;
            end
            if (full_runs < 2 && items_sent > 500 * (full_runs + 1)) begin
                fill_table();
                full_runs++;
                if (full_runs == 1)
                    drain_wait();
            end
            if (!quiet)
                gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                run_transfer(1000);
            end else if (pick < 80) begin
                run_transfer($urandom_range(0, 3));
            end else if (pick < 86) begin
                send_begin(rand_word64(), ($urandom_range(0, 1) == 0) ? CNT_W'(0) :
                           CNT_W'($urandom_range(MAX_TRANSFER + 1, 17'h1FFFF)));
            end else if (pick < 92) begin
                send_begin(rand_word64() | 64'd1, CNT_W'($urandom_range(1, MAX_TRANSFER)));
            end else if (!sb.running) begin
                send_answer(rand_word64());
            end else begin
                run_transfer(1000);
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (sb.mismatch_total == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/dpb_pkg.sv
rtl/dpb_core.sv
rtl/dpb_outq.sv
rtl/dma_prd_table_builder.sv
test/tb_dma_prd_table_builder.sv
